// ----- src/indexed_doubly_linked_list_assert.svh -----
// Assertion macros shared by the list RTL.
`ifndef INDEXED_DOUBLY_LINKED_LIST_ASSERT_SVH
`define INDEXED_DOUBLY_LINKED_LIST_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define IDLL_ASSERT_ALWAYS(LBL, CLK, RSTN, COND) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (COND)) \
    else $error("idll: invariant violated");

// A consequence that must hold in the same cycle as its trigger.
`define IDLL_ASSERT_SAME(LBL, CLK, RSTN, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
    else $error("idll: same-cycle check failed");

// A consequence that must hold in the cycle after its trigger.
`define IDLL_ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
    else $error("idll: next-cycle check failed");

`endif

// ----- src/idll_pkg.sv -----
`default_nettype none

package idll_pkg;

  // Width of a node id on every port and in the link tables.
  localparam int ID_W = 7;
  // Default number of nodes.
  localparam int NODES_DEF = 64;
  // Packed widths of the stream payloads.
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic [1:0] {
    CMD_INS_BEFORE = 2'd0,
    CMD_INS_AFTER  = 2'd1,
    CMD_REMOVE     = 2'd2,
    CMD_WALK       = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_IGNORED  = 2'd1,
    ST_REJECTED = 2'd2
  } status_t;

  // One write to a link table, addressed by node id.
  typedef struct packed {
    logic            we;
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] data;
  } link_wr_t;

endpackage

`default_nettype wire

// ----- src/idll_link_mem.sv -----
`default_nettype none

module idll_link_mem import idll_pkg::*; #(
  parameter int DEPTH = NODES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire link_wr_t        wr,
  input  wire logic [ID_W-1:0] rd_id,
  output logic      [ID_W-1:0] rd_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ID_W-1:0]  link_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [ID_W-1:0]  rdata_r;
  logic [ID_W-1:0]  wr_id_m1;
  logic [ID_W-1:0]  rd_id_m1;
  logic [IDX_W-1:0] widx;
  logic [IDX_W-1:0] ridx;

  // Node id n lives in entry n-1.
  assign wr_id_m1 = wr.id - ID_W'(1);
  assign rd_id_m1 = rd_id - ID_W'(1);
  assign widx     = wr_id_m1[IDX_W-1:0];
  assign ridx     = rd_id_m1[IDX_W-1:0];

  // Valid bits: an entry never written reads as no neighbor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.we) begin
      vld_r[widx] <= 1'b1;
    end
  end

  // Storage with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      link_r[widx] <= wr.data;
    end
    rdata_r <= vld_r[ridx] ? link_r[ridx] : '0;
  end

  assign rd_data = rdata_r;

endmodule

`default_nettype wire

// ----- src/indexed_doubly_linked_list.sv -----
// Ordered list of node ids 1..NODES kept as prev/next link tables and a head
// pointer; after reset the list holds node 1 alone. Each input beat carries a
// command: insert a node before or after a listed anchor, remove a node, or
// walk the list. Insert and remove return one beat with a status (done,
// removal ignored, insert rejected); a walk returns one beat per listed node
// from head to tail, tlast on the final one. One item is handled at a time
// by a small sequencer around two link memories, each with one write port
// and one registered read port. A walk emits one id per cycle while the
// output is not stalled, because each next-link read returns in time to
// address the next one.
`default_nettype none

`include "indexed_doubly_linked_list_assert.svh"

module indexed_doubly_linked_list import idll_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [1:0] command, [8:2] node, [15:9] anchor
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [6:0] node_id, [7] zero
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  output logic                        out_tlast,
  // [1:0] status
  output logic      [OUT_TUSER_W-1:0] out_tuser
);

  localparam int CNT_W = $clog2(NODES);
  localparam logic [ID_W-1:0] MAX_ID = ID_W'(NODES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NODES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDA,
    S_CHK,
    S_INS2,
    S_RMV,
    S_RMV2,
    S_RES,
    S_WALK
  } state_t;

  state_t          state_r, state_nxt;
  cmd_t            cmd_r, cmd_nxt;
  logic [ID_W-1:0] node_r, node_nxt;
  logic [ID_W-1:0] anchor_r, anchor_nxt;
  logic [ID_W-1:0] head_r, head_nxt;
  logic [ID_W-1:0] nb_r, nb_nxt;
  logic            bad_r, bad_nxt;
  logic [ID_W-1:0] t_r, t_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  status_t         status_r, status_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [ID_W-1:0] out_data_r, out_data_nxt;
  logic            out_last_r, out_last_nxt;
  status_t         out_status_r, out_status_nxt;

  cmd_t            in_cmd;
  logic [ID_W-1:0] in_node;
  logic [ID_W-1:0] in_anchor;
  logic [ID_W-1:0] rd_id;
  logic [ID_W-1:0] prev_rdata;
  logic [ID_W-1:0] next_rdata;
  link_wr_t        prev_wr;
  link_wr_t        next_wr;
  logic            out_free;
  logic            after;
  logic            a_listed;
  logic [ID_W-1:0] nb;
  logic            walk_last;

  function automatic logic id_ok(input logic [ID_W-1:0] id);
    return (id != '0) && (id <= MAX_ID);
  endfunction

  // Input beat fields.
  assign in_cmd    = cmd_t'(in_tdata[1:0]);
  assign in_node   = in_tdata[8:2];
  assign in_anchor = in_tdata[15:9];

  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;
  assign after     = (cmd_r == CMD_INS_AFTER);
  assign a_listed  = (prev_rdata != '0) || (next_rdata != '0) || (head_r == anchor_r);
  assign nb        = after ? next_rdata : prev_rdata;
  assign walk_last = (next_rdata == '0) || (cnt_r == CNT_LAST);

  // Link tables.
  idll_link_mem #(.DEPTH(NODES)) u_prev (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (prev_wr),
    .rd_id   (rd_id),
    .rd_data (prev_rdata)
  );

  idll_link_mem #(.DEPTH(NODES)) u_next (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (next_wr),
    .rd_id   (rd_id),
    .rd_data (next_rdata)
  );

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    node_nxt       = node_r;
    anchor_nxt     = anchor_r;
    head_nxt       = head_r;
    nb_nxt         = nb_r;
    bad_nxt        = bad_r;
    t_nxt          = t_r;
    cnt_nxt        = cnt_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    prev_wr        = '0;
    next_wr        = '0;
    rd_id          = node_r;

    unique case (state_r)
      S_IDLE: begin
        rd_id = (in_cmd == CMD_WALK) ? head_r : in_node;
        if (in_tvalid) begin
          cmd_nxt    = in_cmd;
          node_nxt   = in_node;
          anchor_nxt = in_anchor;
          unique case (in_cmd) inside
            CMD_INS_BEFORE, CMD_INS_AFTER: begin
              if (!id_ok(in_node) || !id_ok(in_anchor)) begin
                status_nxt = ST_REJECTED;
                state_nxt  = S_RES;
              end else begin
                state_nxt = S_RDA;
              end
            end
            CMD_REMOVE: begin
              if (!id_ok(in_node)) begin
                status_nxt = ST_IGNORED;
                state_nxt  = S_RES;
              end else begin
                state_nxt = S_RMV;
              end
            end
            default: begin
              t_nxt     = head_r;
              cnt_nxt   = '0;
              state_nxt = S_WALK;
            end
          endcase
        end
      end

      // Links of the new node are back; fetch the anchor's.
      S_RDA: begin
        bad_nxt   = (prev_rdata != '0) || (next_rdata != '0) || (head_r == node_r);
        rd_id     = anchor_r;
        state_nxt = S_CHK;
      end

      // Check the anchor and link the new node to its neighbors.
      S_CHK: begin
        if (bad_r || !a_listed) begin
          status_nxt = ST_REJECTED;
          state_nxt  = S_RES;
        end else begin
          prev_wr   = '{we: 1'b1, id: node_r, data: after ? anchor_r : nb};
          next_wr   = '{we: 1'b1, id: node_r, data: after ? nb : anchor_r};
          nb_nxt    = nb;
          state_nxt = S_INS2;
        end
      end

      // Point the anchor and its old neighbor at the new node.
      S_INS2: begin
        if (after) begin
          prev_wr = '{we: (nb_r != '0), id: nb_r, data: node_r};
          next_wr = '{we: 1'b1, id: anchor_r, data: node_r};
        end else begin
          next_wr = '{we: (nb_r != '0), id: nb_r, data: node_r};
          prev_wr = '{we: 1'b1, id: anchor_r, data: node_r};
          if (head_r == anchor_r) begin
            head_nxt = node_r;
          end
        end
        status_nxt = ST_OK;
        state_nxt  = S_RES;
      end

      // Bridge the neighbors of the removed node.
      S_RMV: begin
        if ((prev_rdata == '0) && (next_rdata == '0)) begin
          status_nxt = ST_IGNORED;
          state_nxt  = S_RES;
        end else begin
          prev_wr = '{we: (next_rdata != '0), id: next_rdata, data: prev_rdata};
          next_wr = '{we: (prev_rdata != '0), id: prev_rdata, data: next_rdata};
          if (prev_rdata == '0) begin
            head_nxt = next_rdata;
          end
          state_nxt = S_RMV2;
        end
      end

      // Clear the removed node's own links.
      S_RMV2: begin
        prev_wr    = '{we: 1'b1, id: node_r, data: '0};
        next_wr    = '{we: 1'b1, id: node_r, data: '0};
        status_nxt = ST_OK;
        state_nxt  = S_RES;
      end

      // Single result beat of an insert or remove.
      S_RES: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = '0;
          out_last_nxt   = 1'b1;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end

      // One id per cycle while the output is free; the next link read is issued as the id leaves.
      S_WALK: begin
        rd_id = (out_free && !walk_last) ? next_rdata : t_r;
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = t_r;
          out_last_nxt   = walk_last;
          out_status_nxt = ST_OK;
          if (walk_last) begin
            state_nxt = S_IDLE;
          end else begin
            t_nxt   = next_rdata;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= ID_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    node_r       <= node_nxt;
    anchor_r     <= anchor_nxt;
    nb_r         <= nb_nxt;
    bad_r        <= bad_nxt;
    t_r          <= t_nxt;
    cnt_r        <= cnt_nxt;
    status_r     <= status_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_status_r;

  // Checks.
  `IDLL_ASSERT_ALWAYS(a_head_valid, clk, rst_n, (head_r != '0) && (head_r <= MAX_ID))
  `IDLL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `IDLL_ASSERT_SAME(a_status_single, clk, rst_n, out_tvalid && (out_tuser != ST_OK),
                    out_tlast && (out_tdata == '0))
  `IDLL_ASSERT_SAME(a_walk_id_valid, clk, rst_n, state_r == S_WALK,
                    (t_r != '0) && (t_r <= MAX_ID))

endmodule

`default_nettype wire
